FILE: rtl/ple_pkg.sv
// Package for the positional list engine.
// Holds the action and status codes, controller state and command types.
// Used by ple_ctrl, ple_datapath and positional_list_engine_core.
`default_nettype none

package ple_pkg;

  localparam logic [2:0] ACT_INS_HEAD = 3'd0;
  localparam logic [2:0] ACT_INS_TAIL = 3'd1;
  localparam logic [2:0] ACT_INS_AT   = 3'd2;
  localparam logic [2:0] ACT_DEL_HEAD = 3'd3;
  localparam logic [2:0] ACT_DEL_TAIL = 3'd4;
  localparam logic [2:0] ACT_DEL_AT   = 3'd5;
  localparam logic [2:0] ACT_SEARCH   = 3'd6;

  localparam logic [1:0] STS_DONE  = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;

  localparam int unsigned POS_W   = 5;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REDUCE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic reduce;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/ple_ctrl.sv
// Controller state machine of the positional list engine.
// Sequences load, execute, reduce and output; depends on ple_pkg.
`default_nettype none

module ple_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output ple_pkg::ctrl_cmd_t     cmd
);
  import ple_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC:   state_next = ST_REDUCE;
      ST_REDUCE: state_next = ST_OUT;
      ST_OUT: begin
        if (m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.load      = s_axis_tvalid;
      end
      ST_EXEC:   cmd.exec = 1'b1;
      ST_REDUCE: cmd.reduce = 1'b1;
      ST_OUT:    m_axis_tvalid = 1'b1;
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/ple_datapath.sv
// Datapath of the positional list engine: a row of shifting cells,
// the list length, a match vector and the result register. Depends on ple_pkg.
`default_nettype none

module ple_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire ple_pkg::ctrl_cmd_t             cmd,
  input  wire logic [2:0]                     action,
  input  wire logic [ple_pkg::POS_W-1:0]      position,
  input  wire logic signed [31:0]             value,
  output logic                                found,
  output logic [ple_pkg::COUNT_W-1:0]         count,
  output logic [1:0]                          status,
  output logic [$clog2(DEPTH+1)-1:0]          len
);
  import ple_pkg::*;

  localparam int unsigned LW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = (LW > POS_W) ? LW : POS_W;

  logic [2:0]        act_r;
  logic [POS_W-1:0]  pos_r;
  logic [31:0]       val_r;
  logic [31:0]       cells [DEPTH];
  logic [DEPTH-1:0]  match;
  logic [LW-1:0]     len_next;
  logic [1:0]        sts_next;
  logic              do_ins;
  logic              do_del;
  logic [IW-1:0]     idx;
  logic [CW-1:0]     len_ext;
  logic [CW-1:0]     pos_ext;
  logic [CW-1:0]     last_ext;
  logic [CW-1:0]     sel;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action;
      pos_r <= position;
      val_r <= value;
    end
  end

  assign len_ext  = CW'(len);
  assign pos_ext  = CW'(pos_r);
  assign last_ext = len_ext - CW'(1);

  always_comb begin
    do_ins   = 1'b0;
    do_del   = 1'b0;
    sts_next = STS_DONE;
    len_next = len;
    sel      = '0;
    case (act_r) inside
      ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_AT: begin
        if (len_ext == CW'(DEPTH)) begin
          sts_next = STS_FULL;
        end else begin
          do_ins   = 1'b1;
          len_next = len + LW'(1);
          if (act_r == ACT_INS_TAIL) begin
            sel = len_ext;
          end else if (act_r == ACT_INS_AT) begin
            sel = (pos_ext < len_ext) ? pos_ext : len_ext;
          end
        end
      end
      ACT_DEL_HEAD, ACT_DEL_TAIL, ACT_DEL_AT: begin
        if (len == '0) begin
          sts_next = STS_EMPTY;
        end else begin
          do_del   = 1'b1;
          len_next = len - LW'(1);
          if (act_r == ACT_DEL_TAIL) begin
            sel = last_ext;
          end else if (act_r == ACT_DEL_AT) begin
            sel = (pos_ext < last_ext) ? pos_ext : last_ext;
          end
        end
      end
      default: begin
        sts_next = STS_DONE;
      end
    endcase
    idx = sel[IW-1:0];
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        if (do_ins) begin
          if (IW'(g) == idx) begin
            cells[g] <= val_r;
          end else if (IW'(g) > idx) begin
            if (g > 0) begin
              cells[g] <= cells[(g > 0) ? g - 1 : 0];
            end
          end
        end else if (do_del) begin
          if (IW'(g) >= idx && g < DEPTH - 1) begin
            cells[g] <= cells[(g < DEPTH - 1) ? g + 1 : g];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        match[g] <= (act_r == ACT_SEARCH) && (CW'(g) < len_ext) && (cells[g] == val_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (cmd.exec) begin
      len <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status <= sts_next;
    end
    if (cmd.reduce) begin
      found <= |match;
    end
  end

  assign count = len_ext[COUNT_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/positional_list_engine_core.sv
// Positional list engine: an ordered list of signed 32-bit values kept in a row of shifting cells.
// After the input transaction the engine executes the shift and compares every cell, then
// reduces the match vector into the result register that is offered at the output.
// A new transaction is taken only once the result of the last one has been taken at the output.
// Synchronous reset empties the list; cell contents are left as they are and never read.
`default_nettype none

module positional_list_engine_core #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // action[2:0], position[7:3], value[39:8]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata   // found[0], count[5:1], status[7:6]
);
  import ple_pkg::*;

  localparam int unsigned LEN_W = $clog2(DEPTH + 1);

  ctrl_cmd_t          cmd;
  logic               found;
  logic [COUNT_W-1:0] count;
  logic [1:0]         status;
  logic [LEN_W-1:0]   len;

  ple_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd           (cmd)
  );

  ple_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .action   (s_axis_tdata[2:0]),
    .position (s_axis_tdata[7:3]),
    .value    (s_axis_tdata[39:8]),
    .found    (found),
    .count    (count),
    .status   (status),
    .len      (len)
  );

  assign m_axis_tdata = {status, count, found};

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(DEPTH))
    else $error("list length exceeds depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second transaction taken while one is in flight");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && status == STS_FULL) |-> (len == LEN_W'(DEPTH)))
    else $error("full status reported on a list that is not full");

  a_found_done: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && found) |-> (status == STS_DONE))
    else $error("found flag raised with an ignored operation");
`endif

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for positional_list_engine_core: a directed table, then random list
// actions, each result compared against the typed reply of its table row or else against
// a list predictor kept inside the bench. Depends on ple_pkg and the engine RTL only.

module tb;
  import ple_pkg::*;

  localparam int unsigned LIST_DEPTH   = 16;
  localparam int unsigned RANDOM_ITEMS = 830;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DIR_ROWS     = 23;
  localparam logic [2:0]  ACT_NOP      = 3'd7;

  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] count;
    logic [1:0]         status;
  } list_reply_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [POS_W-1:0] position;
    logic [31:0]      value;
    bit               typed;
    list_reply_t      reply;
  } list_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  logic [31:0] held_vals[$];
  list_reply_t pending_replies[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;

  list_row_t dir_rows [DIR_ROWS] = '{
    '{ACT_DEL_HEAD, 5'd0,  32'h0000_0000, 1'b1, '{1'b0, 5'd0, STS_EMPTY}},
    '{ACT_DEL_TAIL, 5'd0,  32'h0000_0000, 1'b1, '{1'b0, 5'd0, STS_EMPTY}},
    '{ACT_DEL_AT,   5'd31, 32'h0000_0000, 1'b1, '{1'b0, 5'd0, STS_EMPTY}},
    '{ACT_SEARCH,   5'd0,  32'h0000_0000, 1'b1, '{1'b0, 5'd0, STS_DONE}},
    '{ACT_INS_AT,   5'd31, 32'h1234_5678, 1'b1, '{1'b0, 5'd1, STS_DONE}},
    '{ACT_SEARCH,   5'd0,  32'h1234_5678, 1'b1, '{1'b1, 5'd1, STS_DONE}},
    '{ACT_DEL_AT,   5'd16, 32'h0000_0000, 1'b1, '{1'b0, 5'd0, STS_DONE}},
    '{ACT_INS_HEAD, 5'd0,  32'h7FFF_FFFF, 1'b1, '{1'b0, 5'd1, STS_DONE}},
    '{ACT_INS_TAIL, 5'd0,  32'h8000_0000, 1'b1, '{1'b0, 5'd2, STS_DONE}},
    '{ACT_SEARCH,   5'd0,  32'h8000_0000, 1'b1, '{1'b1, 5'd2, STS_DONE}},
    '{ACT_SEARCH,   5'd0,  32'hFFFF_FFFF, 1'b1, '{1'b0, 5'd2, STS_DONE}},
    '{ACT_INS_AT,   5'd1,  32'hFFFF_FFFF, 1'b0, '0},
    '{ACT_INS_AT,   5'd0,  32'h0000_0000, 1'b0, '0},
    '{ACT_NOP,      5'd31, 32'hFFFF_FFFF, 1'b1, '{1'b0, 5'd4, STS_DONE}},
    '{ACT_SEARCH,   5'd0,  32'h7FFF_FFFF, 1'b0, '0},
    '{ACT_DEL_AT,   5'd1,  32'h0000_0000, 1'b0, '0},
    '{ACT_DEL_AT,   5'd31, 32'h0000_0000, 1'b0, '0},
    '{ACT_INS_AT,   5'd16, 32'hA5A5_A5A5, 1'b0, '0},
    '{ACT_DEL_HEAD, 5'd0,  32'h0000_0000, 1'b0, '0},
    '{ACT_DEL_TAIL, 5'd0,  32'h0000_0000, 1'b0, '0},
    '{ACT_SEARCH,   5'd0,  32'hA5A5_A5A5, 1'b0, '0},
    '{ACT_DEL_TAIL, 5'd0,  32'h0000_0000, 1'b0, '0},
    '{ACT_DEL_HEAD, 5'd0,  32'h0000_0000, 1'b1, '{1'b0, 5'd0, STS_EMPTY}}
  };

  positional_list_engine_core #(
    .DEPTH(LIST_DEPTH)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic list_reply_t predict_list_action(input logic [2:0] act,
                                                      input logic [POS_W-1:0] pos,
                                                      input logic [31:0] val);
    list_reply_t rep;
    int unsigned slot;
    rep = '{found: 1'b0, count: '0, status: STS_DONE};
    case (act) inside
      ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_AT: begin
        if (held_vals.size() >= LIST_DEPTH) begin
          rep.status = STS_FULL;
        end else if (act == ACT_INS_HEAD) begin
          held_vals.push_front(val);
        end else if (act == ACT_INS_TAIL) begin
          held_vals.push_back(val);
        end else begin
          slot = (pos < held_vals.size()) ? pos : held_vals.size();
          held_vals.insert(slot, val);
        end
      end
      ACT_DEL_HEAD, ACT_DEL_TAIL, ACT_DEL_AT: begin
        if (held_vals.size() == 0) begin
          rep.status = STS_EMPTY;
        end else if (act == ACT_DEL_HEAD) begin
          void'(held_vals.pop_front());
        end else if (act == ACT_DEL_TAIL) begin
          void'(held_vals.pop_back());
        end else begin
          slot = (pos < held_vals.size() - 1) ? pos : held_vals.size() - 1;
          held_vals.delete(slot);
        end
      end
      ACT_SEARCH: begin
        foreach (held_vals[i]) begin
          if (held_vals[i] == val) rep.found = 1'b1;
        end
      end
      default: ;
    endcase
    rep.count = COUNT_W'(held_vals.size());
    return rep;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    if (roll < 4) return $urandom_range(0, 7);
    return $urandom;
  endfunction

  task automatic send_item(input logic [2:0] act, input logic [POS_W-1:0] pos,
                           input logic [31:0] val, input bit typed,
                           input list_reply_t typed_reply);
    list_reply_t predicted;
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {val, pos, act};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predicted = predict_list_action(act, pos, val);
    pending_replies.push_back(typed ? typed_reply : predicted);
  endtask

  initial begin : source
    int unsigned trend;
    int unsigned roll;
    int unsigned grow;
    logic [2:0] act;
    logic [POS_W-1:0] pos;
    logic [31:0] val;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_item(dir_rows[r].action, dir_rows[r].position, dir_rows[r].value,
                dir_rows[r].typed, dir_rows[r].reply);
    end
    trend = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        trend = $urandom_range(0, 2);
        quiet = ($urandom_range(0, 4) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        act = ACT_NOP;
      end else if (roll < 22) begin
        act = ACT_SEARCH;
      end else begin
        grow = (trend == 0) ? 75 : (trend == 1) ? 25 : 50;
        if ($urandom_range(0, 99) < grow) act = 3'($urandom_range(0, 2));
        else act = 3'(ACT_DEL_HEAD + $urandom_range(0, 2));
      end
      pos = ($urandom_range(0, 9) == 0) ? POS_W'($urandom_range(17, 31))
                                        : POS_W'($urandom_range(0, 16));
      val = pick_value();
      if (act == ACT_SEARCH && held_vals.size() > 0 && $urandom_range(0, 1) == 1) begin
        val = held_vals[$urandom_range(0, held_vals.size() - 1)];
      end
      send_item(act, pos, val, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : sink
    int unsigned hold;
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    list_reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected transaction: tdata=%h", m_axis_tdata);
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tdata[0] !== want.found || m_axis_tdata[5:1] !== want.count ||
            m_axis_tdata[7:6] !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $write("Mismatch: expected found=%0d count=%0d status=%0d, ",
                   want.found, want.count, want.status);
            $display("got found=%0d count=%0d status=%0d",
                     m_axis_tdata[0], m_axis_tdata[5:1], m_axis_tdata[7:6]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
